### hw/rtl/sts_pkg.sv
// Shared types, constants and helper functions for the SQL token scanner.
`default_nettype none
package sts_pkg;

   localparam int POSITION_BITS = 16;
   localparam int LENGTH_BITS   = 16;
   localparam int KEYWORD_CHARS = 8;
   localparam int MAX_RESULTS   = 5;
   localparam int KW_COUNT      = 32;
   localparam int QUEUE_DEPTH   = 4;

   localparam int KW_IDX_BITS   = $clog2(KEYWORD_CHARS);
   localparam int RUN_CNT_BITS  = $clog2(MAX_RESULTS + 1);
   localparam int Q_PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // Token type codes
   localparam logic [5:0] T_IDENT   = 6'd32;
   localparam logic [5:0] T_NUMBER  = 6'd33;
   localparam logic [5:0] T_STRING  = 6'd34;
   localparam logic [5:0] T_EQ      = 6'd35;
   localparam logic [5:0] T_LE      = 6'd36;
   localparam logic [5:0] T_NE      = 6'd37;
   localparam logic [5:0] T_LT      = 6'd38;
   localparam logic [5:0] T_GE      = 6'd39;
   localparam logic [5:0] T_GT      = 6'd40;
   localparam logic [5:0] T_PLUS    = 6'd41;
   localparam logic [5:0] T_MINUS   = 6'd42;
   localparam logic [5:0] T_STAR    = 6'd43;
   localparam logic [5:0] T_SLASH   = 6'd44;
   localparam logic [5:0] T_PCT     = 6'd45;
   localparam logic [5:0] T_LPAREN  = 6'd46;
   localparam logic [5:0] T_RPAREN  = 6'd47;
   localparam logic [5:0] T_COMMA   = 6'd48;
   localparam logic [5:0] T_DOT     = 6'd49;
   localparam logic [5:0] T_SEMI    = 6'd50;
   localparam logic [5:0] T_UNKNOWN = 6'd51;
   localparam logic [5:0] T_END     = 6'd52;

   // Request commands and item kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   // Characters
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_SQUOTE = "'";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_LT     = "<";
   localparam logic [7:0] CH_GT     = ">";
   localparam logic [7:0] CH_BANG   = "!";
   localparam logic [7:0] CH_EQ     = "=";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_BSLASH = "\\";
   localparam logic [7:0] CH_LOW_E  = "e";
   localparam logic [7:0] CH_UP_E   = "E";
   localparam logic [7:0] CH_LOW_N  = "n";
   localparam logic [7:0] CH_LOW_T  = "t";
   localparam logic [7:0] CH_LOW_R  = "r";

   typedef enum logic [3:0] {
      M_IDLE, M_MINUS, M_COMMENT, M_LT, M_GT, M_BANG, M_STR, M_ESC,
      M_IDENT, M_INT, M_DOT, M_FRAC, M_EXPS, M_EXP
   } scan_mode_type;

   typedef struct packed {
      logic                     item_kind;
      logic [7:0]               value_byte;
      logic [5:0]               token_type;
      logic [POSITION_BITS-1:0] token_line;
      logic [POSITION_BITS-1:0] token_column;
      logic [LENGTH_BITS-1:0]   token_length;
   } item_type;

   // All results of one request
   typedef struct packed {
      item_type [MAX_RESULTS-1:0] items;
      logic [RUN_CNT_BITS-1:0]    count;
   } run_type;

   // Keywords, right-justified, first character highest
   localparam logic [8*KEYWORD_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
      "SELECT", "INSERT", "UPDATE", "DELETE", "CREATE", "TABLE", "FROM",
      "WHERE", "AND", "OR", "NOT", "JOIN", "INNER", "LEFT", "RIGHT", "ON",
      "GROUP", "BY", "HAVING", "ORDER", "ASC", "DESC", "VALUES", "SET",
      "NULL", "AS", "DISTINCT", "COUNT", "SUM", "AVG", "MIN", "MAX"};
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3,
      4'd4, 4'd5, 4'd4, 4'd5, 4'd2, 4'd5, 4'd2, 4'd6, 4'd5, 4'd3, 4'd4,
      4'd6, 4'd3, 4'd4, 4'd2, 4'd8, 4'd5, 4'd3, 4'd3, 4'd3, 4'd3};

   function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [POSITION_BITS-1:0] adv_line(
      input logic [POSITION_BITS-1:0] l, input logic [7:0] b);
      return (b == CH_LF) ? pos_inc(l) : l;
   endfunction

   function automatic logic [POSITION_BITS-1:0] adv_col(
      input logic [POSITION_BITS-1:0] c, input logic [7:0] b);
      return (b == CH_LF) ? POSITION_BITS'(1) : pos_inc(c);
   endfunction

   function automatic logic is_dec_digit(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_word_char(input logic [7:0] b);
      return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      return ((b >= "a") && (b <= "z")) ? b - 8'd32 : b;
   endfunction

   // Single-byte operators; bit 6 flags a match
   function automatic logic [6:0] single_op(input logic [7:0] b);
      logic [6:0] r;
      r = '0;
      unique case (b)
         "=":     r = {1'b1, T_EQ};
         "+":     r = {1'b1, T_PLUS};
         "*":     r = {1'b1, T_STAR};
         "/":     r = {1'b1, T_SLASH};
         "%":     r = {1'b1, T_PCT};
         "(":     r = {1'b1, T_LPAREN};
         ")":     r = {1'b1, T_RPAREN};
         ",":     r = {1'b1, T_COMMA};
         ".":     r = {1'b1, T_DOT};
         ";":     r = {1'b1, T_SEMI};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic item_type mk_item(
      input logic kind, input logic [7:0] val, input logic [5:0] ttyp,
      input logic [POSITION_BITS-1:0] line, input logic [POSITION_BITS-1:0] col,
      input logic [LENGTH_BITS-1:0] len);
      item_type it;
      it.item_kind    = kind;
      it.value_byte   = val;
      it.token_type   = ttyp;
      it.token_line   = line;
      it.token_column = col;
      it.token_length = len;
      return it;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/sts_front.sv
// Scanner front: accepts requests, runs the lexer state and builds each result run.
`default_nettype none
module sts_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic                         req_command,
   input  wire logic [7:0]                   req_input_byte,
   output sts_pkg::run_type                  push_run,
   output logic                              push_valid
);
   import sts_pkg::*;

   scan_mode_type            mode_ff, mode_in;
   logic [POSITION_BITS-1:0] cur_line_ff, cur_line_in;
   logic [POSITION_BITS-1:0] cur_col_ff, cur_col_in;
   logic [POSITION_BITS-1:0] st_line_ff, st_line_in;
   logic [POSITION_BITS-1:0] st_col_ff, st_col_in;
   logic [POSITION_BITS-1:0] dot_col_ff, dot_col_in;
   logic [LENGTH_BITS-1:0]   lex_cnt_ff, lex_cnt_in;
   logic                     quote_dbl_ff, quote_dbl_in;
   logic [7:0]               kw_buf_ff [KEYWORD_CHARS];

   logic                     fire;
   logic                     kw_we;
   logic [KW_IDX_BITS-1:0]   kw_idx;
   logic [7:0]               kw_data;
   logic                     do_flush, do_fresh;
   logic [5:0]               ident_type;
   run_type                  run;
   logic [7:0]               b;
   logic [7:0]               quote_ch;
   logic [7:0]               esc_ch;
   logic [6:0]               op;

   assign fire = req_valid && !req_stall;
   assign b    = req_input_byte;

   // Keyword match of the buffered identifier; first hit in table order wins
   always_comb begin
      logic hit;
      ident_type = T_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         hit = (lex_cnt_ff <= LENGTH_BITS'(KEYWORD_CHARS)) &&
               (lex_cnt_ff == LENGTH_BITS'(KW_LEN[k]));
         for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (LENGTH_BITS'(i) < lex_cnt_ff &&
                kw_buf_ff[i] != KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i) * 8 +: 8])
               hit = 1'b0;
         end
         if (hit) ident_type = 6'(k);
      end
   end

   // Lexer step: state update and result run for one request
   always_comb begin
      mode_in      = mode_ff;
      cur_line_in  = cur_line_ff;
      cur_col_in   = cur_col_ff;
      st_line_in   = st_line_ff;
      st_col_in    = st_col_ff;
      dot_col_in   = dot_col_ff;
      lex_cnt_in   = lex_cnt_ff;
      quote_dbl_in = quote_dbl_ff;
      kw_we        = 1'b0;
      kw_idx       = lex_cnt_ff[KW_IDX_BITS-1:0];
      kw_data      = to_upper(b);
      run          = '0;
      do_flush     = 1'b0;
      do_fresh     = 1'b0;
      quote_ch     = quote_dbl_ff ? CH_DQUOTE : CH_SQUOTE;
      op           = single_op(b);
      unique case (b)
         CH_LOW_N: esc_ch = CH_LF;
         CH_LOW_T: esc_ch = CH_TAB;
         CH_LOW_R: esc_ch = CH_CR;
         default:  esc_ch = b;
      endcase

      // mode-specific work: continue or complete the pending token, or flag it to be ended
      if (req_command == CMD_END) begin
         do_flush = 1'b1;
      end else begin
         unique case (mode_ff)
            M_COMMENT: begin
               if (b == CH_LF) do_fresh = 1'b1;
               else cur_col_in = adv_col(cur_col_ff, b);
            end
            M_MINUS: begin
               if (b == CH_MINUS) begin
                  cur_line_in = adv_line(cur_line_ff, b);
                  cur_col_in  = adv_col(cur_col_ff, b);
                  mode_in     = M_COMMENT;
               end else begin
                  do_flush = 1'b1; do_fresh = 1'b1;
               end
            end
            M_LT, M_GT, M_BANG: begin
               if (b == CH_EQ || (mode_ff == M_LT && b == CH_GT)) begin
                  cur_line_in = adv_line(cur_line_ff, b);
                  cur_col_in  = adv_col(cur_col_ff, b);
                  run.items[0] = mk_item(KIND_BYTE, (mode_ff == M_LT) ? CH_LT :
                                         (mode_ff == M_GT) ? CH_GT : CH_BANG,
                                         '0, '0, '0, '0);
                  run.items[1] = mk_item(KIND_BYTE, b, '0, '0, '0, '0);
                  run.items[2] = mk_item(KIND_RECORD, '0,
                                         (mode_ff == M_GT) ? T_GE :
                                         (mode_ff == M_BANG || b == CH_GT) ? T_NE : T_LE,
                                         st_line_ff, st_col_ff, LENGTH_BITS'(2));
                  run.count = RUN_CNT_BITS'(3);
                  mode_in   = M_IDLE;
               end else begin
                  do_flush = 1'b1; do_fresh = 1'b1;
               end
            end
            M_STR: begin
               cur_line_in = adv_line(cur_line_ff, b);
               cur_col_in  = adv_col(cur_col_ff, b);
               if (b == quote_ch) begin
                  run.items[0] = mk_item(KIND_RECORD, '0, T_STRING, st_line_ff,
                                         pos_inc(st_col_ff), lex_cnt_ff);
                  run.count = RUN_CNT_BITS'(1);
                  mode_in   = M_IDLE;
               end else if (b == CH_BSLASH) begin
                  mode_in = M_ESC;
               end else begin
                  run.items[0] = mk_item(KIND_BYTE, b, '0, '0, '0, '0);
                  run.count  = RUN_CNT_BITS'(1);
                  lex_cnt_in = len_inc(lex_cnt_ff);
               end
            end
            M_ESC: begin
               cur_line_in  = adv_line(cur_line_ff, b);
               cur_col_in   = adv_col(cur_col_ff, b);
               run.items[0] = mk_item(KIND_BYTE, esc_ch, '0, '0, '0, '0);
               run.count    = RUN_CNT_BITS'(1);
               lex_cnt_in   = len_inc(lex_cnt_ff);
               mode_in      = M_STR;
            end
            M_IDENT: begin
               if (is_word_char(b) || is_dec_digit(b)) begin
                  cur_line_in  = adv_line(cur_line_ff, b);
                  cur_col_in   = adv_col(cur_col_ff, b);
                  kw_we        = lex_cnt_ff < LENGTH_BITS'(KEYWORD_CHARS);
                  run.items[0] = mk_item(KIND_BYTE, b, '0, '0, '0, '0);
                  run.count    = RUN_CNT_BITS'(1);
                  lex_cnt_in   = len_inc(lex_cnt_ff);
               end else begin
                  do_flush = 1'b1; do_fresh = 1'b1;
               end
            end
            M_INT, M_FRAC, M_EXPS, M_EXP: begin
               if ((mode_ff == M_EXPS) ?
                   (is_dec_digit(b) || b == CH_PLUS || b == CH_MINUS)
                   : is_dec_digit(b)) begin
                  cur_line_in  = adv_line(cur_line_ff, b);
                  cur_col_in   = adv_col(cur_col_ff, b);
                  run.items[0] = mk_item(KIND_BYTE, b, '0, '0, '0, '0);
                  run.count    = RUN_CNT_BITS'(1);
                  lex_cnt_in   = len_inc(lex_cnt_ff);
                  if (mode_ff == M_EXPS) mode_in = M_EXP;
               end else if (mode_ff == M_INT && b == CH_DOT) begin
                  dot_col_in = cur_col_ff;
                  cur_col_in = adv_col(cur_col_ff, b);
                  mode_in    = M_DOT;
               end else if ((mode_ff == M_INT || mode_ff == M_FRAC) &&
                            (b == CH_LOW_E || b == CH_UP_E)) begin
                  cur_col_in   = adv_col(cur_col_ff, b);
                  run.items[0] = mk_item(KIND_BYTE, b, '0, '0, '0, '0);
                  run.count    = RUN_CNT_BITS'(1);
                  lex_cnt_in   = len_inc(lex_cnt_ff);
                  mode_in      = M_EXPS;
               end else begin
                  do_flush = 1'b1; do_fresh = 1'b1;
               end
            end
            M_DOT: begin
               if (is_dec_digit(b)) begin
                  cur_col_in   = adv_col(cur_col_ff, b);
                  run.items[0] = mk_item(KIND_BYTE, CH_DOT, '0, '0, '0, '0);
                  run.items[1] = mk_item(KIND_BYTE, b, '0, '0, '0, '0);
                  run.count    = RUN_CNT_BITS'(2);
                  lex_cnt_in   = len_inc(len_inc(lex_cnt_ff));
                  mode_in      = M_FRAC;
               end else begin
                  do_flush = 1'b1; do_fresh = 1'b1;
               end
            end
            default: do_fresh = 1'b1;
         endcase
      end

      // end the pending token
      if (do_flush) begin
         unique case (mode_ff)
            M_MINUS, M_LT, M_GT, M_BANG: begin
               run.items[run.count] = mk_item(KIND_BYTE,
                  (mode_ff == M_MINUS) ? CH_MINUS : (mode_ff == M_LT) ? CH_LT :
                  (mode_ff == M_GT) ? CH_GT : CH_BANG, '0, '0, '0, '0);
               run.count = run.count + 1'b1;
               run.items[run.count] = mk_item(KIND_RECORD, '0,
                  (mode_ff == M_MINUS) ? T_MINUS : (mode_ff == M_LT) ? T_LT :
                  (mode_ff == M_GT) ? T_GT : T_UNKNOWN, st_line_ff,
                  (mode_ff == M_BANG) ? pos_inc(st_col_ff) : st_col_ff,
                  LENGTH_BITS'(1));
               run.count = run.count + 1'b1;
            end
            M_STR, M_ESC, M_IDENT, M_INT, M_FRAC, M_EXPS, M_EXP, M_DOT: begin
               run.items[run.count] = mk_item(KIND_RECORD, '0,
                  (mode_ff == M_STR || mode_ff == M_ESC) ? T_STRING :
                  (mode_ff == M_IDENT) ? ident_type : T_NUMBER,
                  st_line_ff, pos_inc(st_col_ff), lex_cnt_ff);
               run.count = run.count + 1'b1;
               if (mode_ff == M_DOT) begin
                  run.items[run.count] = mk_item(KIND_BYTE, CH_DOT, '0, '0, '0, '0);
                  run.count = run.count + 1'b1;
                  run.items[run.count] = mk_item(KIND_RECORD, '0, T_DOT, st_line_ff,
                                                 dot_col_ff, LENGTH_BITS'(1));
                  run.count = run.count + 1'b1;
               end
            end
            default: ;
         endcase
         mode_in = M_IDLE;
      end

      // scan the byte afresh
      if (do_fresh) begin
         mode_in = M_IDLE;
         if (is_space(b)) begin
            cur_line_in = adv_line(cur_line_ff, b);
            cur_col_in  = adv_col(cur_col_ff, b);
         end else begin
            st_line_in  = cur_line_ff;
            st_col_in   = cur_col_ff;
            lex_cnt_in  = '0;
            cur_col_in  = pos_inc(cur_col_ff);
            if (b == CH_MINUS) begin
               mode_in = M_MINUS;
            end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
               quote_dbl_in = (b == CH_DQUOTE);
               mode_in      = M_STR;
            end else if (b == CH_LT) begin
               mode_in = M_LT;
            end else if (b == CH_GT) begin
               mode_in = M_GT;
            end else if (b == CH_BANG) begin
               mode_in = M_BANG;
            end else if (is_dec_digit(b) || is_word_char(b)) begin
               cur_col_in = pos_inc(pos_inc(cur_col_ff));
               run.items[run.count] = mk_item(KIND_BYTE, b, '0, '0, '0, '0);
               run.count  = run.count + 1'b1;
               lex_cnt_in = LENGTH_BITS'(1);
               if (is_dec_digit(b)) begin
                  mode_in = M_INT;
               end else begin
                  kw_we   = 1'b1;
                  kw_idx  = '0;
                  mode_in = M_IDENT;
               end
            end else begin
               run.items[run.count] = mk_item(KIND_BYTE, b, '0, '0, '0, '0);
               run.count = run.count + 1'b1;
               run.items[run.count] = mk_item(KIND_RECORD, '0,
                  op[6] ? op[5:0] : T_UNKNOWN, cur_line_ff,
                  op[6] ? cur_col_ff : pos_inc(cur_col_ff), LENGTH_BITS'(1));
               run.count = run.count + 1'b1;
            end
         end
      end

      // end of input: end record, then back to reset state
      if (req_command == CMD_END) begin
         run.items[run.count] = mk_item(KIND_RECORD, '0, T_END, cur_line_ff,
                                        cur_col_ff, '0);
         run.count    = run.count + 1'b1;
         mode_in      = M_IDLE;
         cur_line_in  = POSITION_BITS'(1);
         cur_col_in   = POSITION_BITS'(1);
         st_line_in   = POSITION_BITS'(1);
         st_col_in    = POSITION_BITS'(1);
         dot_col_in   = '0;
         lex_cnt_in   = '0;
         quote_dbl_in = 1'b0;
      end
   end

   assign push_run   = run;
   assign push_valid = fire && (run.count != '0);

   // Lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_IDLE;
         cur_line_ff  <= POSITION_BITS'(1);
         cur_col_ff   <= POSITION_BITS'(1);
         st_line_ff   <= POSITION_BITS'(1);
         st_col_ff    <= POSITION_BITS'(1);
         dot_col_ff   <= '0;
         lex_cnt_ff   <= '0;
         quote_dbl_ff <= 1'b0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         cur_line_ff  <= cur_line_in;
         cur_col_ff   <= cur_col_in;
         st_line_ff   <= st_line_in;
         st_col_ff    <= st_col_in;
         dot_col_ff   <= dot_col_in;
         lex_cnt_ff   <= lex_cnt_in;
         quote_dbl_ff <= quote_dbl_in;
      end
   end

   // Keyword buffer, upper-cased identifier prefix
   always_ff @(posedge clock) begin
      if (fire && kw_we && req_command == CMD_BYTE) begin
         kw_buf_ff[kw_idx] <= kw_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/sts_queue.sv
// Short queue of result runs between the scanner front and the output back end.
`default_nettype none
module sts_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire sts_pkg::run_type push_run,
   input  wire logic             pop,
   output sts_pkg::run_type      head_run,
   output logic                  head_valid,
   output logic                  full
);
   import sts_pkg::*;

   run_type                 slot_ff [QUEUE_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_BITS-1:0]   cnt_ff;

   assign head_run   = slot_ff[rd_ptr_ff];
   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == Q_CNT_BITS'(QUEUE_DEPTH));

   // Storage
   always_ff @(posedge clock) begin
      if (push_valid) slot_ff[wr_ptr_ff] <= push_run;
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push_valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)        rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push_valid && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push_valid) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/sts_back.sv
// Output back end: walks each queued run and drives the response register.
`default_nettype none
module sts_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sts_pkg::run_type                  head_run,
   input  wire logic                              head_valid,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_item_kind,
   output logic [7:0]                             rsp_value_byte,
   output logic [5:0]                             rsp_token_type,
   output logic [sts_pkg::POSITION_BITS-1:0]      rsp_token_line,
   output logic [sts_pkg::POSITION_BITS-1:0]      rsp_token_column,
   output logic [sts_pkg::LENGTH_BITS-1:0]        rsp_token_length,
   output logic                                   rsp_last_of_run
);
   import sts_pkg::*;

   logic [RUN_CNT_BITS-1:0] idx_ff;
   logic                    valid_ff;
   item_type                item_ff;
   logic                    last_ff;
   logic                    load;
   logic                    is_last;

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign is_last = (idx_ff == head_run.count - 1'b1);
   assign pop     = load && is_last;

   // Item index within the head run
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (load) begin
         idx_ff <= is_last ? '0 : idx_ff + 1'b1;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= head_run.items[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_item_kind    = item_ff.item_kind;
   assign rsp_value_byte   = item_ff.value_byte;
   assign rsp_token_type   = item_ff.token_type;
   assign rsp_token_line   = item_ff.token_line;
   assign rsp_token_column = item_ff.token_column;
   assign rsp_token_length = item_ff.token_length;
   assign rsp_last_of_run  = last_ff;

endmodule
`default_nettype wire

### hw/rtl/sql_token_scanner_top.sv
// Top level of the streaming SQL token scanner.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | command, input_byte
//  rsp     | out       | rsp_valid/rsp_stall | kind, byte, type, line, column, length, last
//
// One request is taken per cycle while req_stall is low; its whole run of up to five
// results is built in that cycle and written to a four-entry run queue. Results leave
// one per cycle from the output register while rsp_stall is low.
// req_stall rises only while the run queue is full. Reset is synchronous and
// returns the scanner to line 1, column 1, between tokens.
`default_nettype none
module sql_token_scanner_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_command,
   input  wire logic [7:0]                        req_input_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_item_kind,
   output logic [7:0]                             rsp_value_byte,
   output logic [5:0]                             rsp_token_type,
   output logic [sts_pkg::POSITION_BITS-1:0]      rsp_token_line,
   output logic [sts_pkg::POSITION_BITS-1:0]      rsp_token_column,
   output logic [sts_pkg::LENGTH_BITS-1:0]        rsp_token_length,
   output logic                                   rsp_last_of_run
);
   import sts_pkg::*;

   run_type push_run, head_run;
   logic    push_valid, head_valid, pop, full;

   assign req_stall = full;

   sts_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (full),
      .req_command    (req_command),
      .req_input_byte (req_input_byte),
      .push_run       (push_run),
      .push_valid     (push_valid)
   );

   sts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_run   (push_run),
      .pop        (pop),
      .head_run   (head_run),
      .head_valid (head_valid),
      .full       (full)
   );

   sts_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_run         (head_run),
      .head_valid       (head_valid),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_token_type   (rsp_token_type),
      .rsp_token_line   (rsp_token_line),
      .rsp_token_column (rsp_token_column),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
`default_nettype wire

### tb/sv/sql_token_scanner_top_tb.sv
// Self-checking testbench for the streaming SQL token scanner: directed table, random SQL.
`timescale 1ns / 1ps
`default_nettype none
module sql_token_scanner_top_tb;
   import sts_pkg::*;

   localparam int CYCLE_LIMIT = 20000;

   // One request as offered to the scanner
   typedef struct {
      bit       cmd;
      bit [7:0] data;
      int       phase;
   } request_type;

   // One result item as the scanner should deliver it
   typedef struct {
      logic        kind;
      logic [7:0]  val;
      logic [5:0]  typ;
      logic [15:0] line;
      logic [15:0] col;
      logic [15:0] len;
      logic        last;
   } lexeme_type;

   // Directed row: text (or one raw byte), optional end of input, typed final record
   typedef struct {
      string      text;
      int         raw;
      bit         eoi;
      bit         chk;
      logic [5:0] typ;
      int         line;
      int         col;
      int         len;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [7:0]  req_input_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_item_kind;
   logic [7:0]  rsp_value_byte;
   logic [5:0]  rsp_token_type;
   logic [15:0] rsp_token_line;
   logic [15:0] rsp_token_column;
   logic [15:0] rsp_token_length;
   logic        rsp_last_of_run;

   sql_token_scanner_top dut (.*);

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Keywords in token-code order
   string keywords [32] = '{
      "SELECT", "INSERT", "UPDATE", "DELETE", "CREATE", "TABLE", "FROM",
      "WHERE", "AND", "OR", "NOT", "JOIN", "INNER", "LEFT", "RIGHT", "ON",
      "GROUP", "BY", "HAVING", "ORDER", "ASC", "DESC", "VALUES", "SET",
      "NULL", "AS", "DISTINCT", "COUNT", "SUM", "AVG", "MIN", "MAX"};

   plan_row_type plan [8] = '{
      '{";",  -1, 1'b0, 1'b1, T_SEMI,    1, 1, 1},
      '{"<>", -1, 1'b0, 1'b1, T_NE,      1, 2, 2},
      '{"",   -1, 1'b1, 1'b1, T_END,     1, 4, 0},
      '{"",  255, 1'b0, 1'b1, T_UNKNOWN, 1, 2, 1},
      '{"",    0, 1'b0, 1'b1, T_UNKNOWN, 1, 3, 1},
      '{"",   -1, 1'b1, 1'b1, T_END,     1, 3, 0},
      '{"select Distinct 1.5e-3'\\n'!x3.--c\n>=\"\\", -1, 1'b0, 1'b0, T_END, 0, 0, 0},
      '{"",   -1, 1'b1, 1'b1, T_END,     2, 5, 0}};

   request_type requests [$];
   lexeme_type  tokens_expected [$];
   lexeme_type  run_items [$];
   lexeme_type  last_record;
   int          errors;
   int          results_seen;
   int          records_seen;
   int          cycles;
   int          src_idle_pct;
   int          dst_stall_pct;
   bit          want_hold;
   int          hold_left;
   int          random_start;

   // Scanner shadow state
   scan_mode_type mode;
   logic [7:0]    kw_buf [8];
   logic [15:0]   cur_line, cur_col, st_line, st_col, lex_cnt, dot_col;
   bit            dq;

   function automatic logic [15:0] up16(input logic [15:0] v);
      return (&v) ? v : v + 16'd1;
   endfunction

   function automatic bit digit_ch(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit alpha_ch(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic bit blank_ch(input logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   task automatic report(input string what, input int exp_v, input int got_v);
      $display("MISMATCH %s: expected %0d got %0d (cycle %0d)", what, exp_v, got_v, cycles);
      errors++;
   endtask

   task automatic lex_reset();
      mode = M_IDLE;
      foreach (kw_buf[i]) kw_buf[i] = 8'd0;
      cur_line = 16'd1; cur_col = 16'd1;
      st_line = 16'd1; st_col = 16'd1;
      lex_cnt = 16'd0; dot_col = 16'd0;
      dq = 1'b0;
   endtask

   task automatic emit(input logic kind, input logic [7:0] val, input logic [5:0] typ,
                       input logic [15:0] line, input logic [15:0] col,
                       input logic [15:0] len);
      lexeme_type it;
      it = '{kind, val, typ, line, col, len, 1'b0};
      run_items.insert(run_items.size(), it);
      if (kind == KIND_RECORD) last_record = it;
   endtask

   task automatic put_byte(input logic [7:0] b);
      emit(KIND_BYTE, b, 6'd0, 16'd0, 16'd0, 16'd0);
   endtask

   task automatic put_rec(input logic [5:0] typ, input logic [15:0] col,
                          input logic [15:0] len);
      emit(KIND_RECORD, 8'd0, typ, st_line, col, len);
   endtask

   task automatic step_pos(input logic [7:0] b);
      if (b == CH_LF) begin
         cur_line = up16(cur_line);
         cur_col = 16'd1;
      end else begin
         cur_col = up16(cur_col);
      end
   endtask

   task automatic count_byte(input logic [7:0] b);
      put_byte(b);
      if (!(&lex_cnt)) lex_cnt++;
   endtask

   // Keyword match only when the whole identifier fits in the buffer
   task automatic close_ident();
      logic [5:0] typ;
      bit         same;
      typ = T_IDENT;
      if (lex_cnt <= 8) begin
         for (int k = 31; k >= 0; k--) begin
            same = keywords[k].len() == lex_cnt;
            for (int i = 0; i < lex_cnt && same; i++)
               if (kw_buf[i] != keywords[k][i]) same = 1'b0;
            if (same) typ = 6'(k);
         end
      end
      put_rec(typ, up16(st_col), lex_cnt);
   endtask

   task automatic add_ident(input logic [7:0] b);
      if (lex_cnt < 8) kw_buf[lex_cnt] = (b >= "a" && b <= "z") ? b - 8'd32 : b;
      count_byte(b);
   endtask

   // Start of a new token (or skipped whitespace)
   task automatic begin_token(input logic [7:0] b);
      logic [5:0] op;
      bit         is_op;
      is_op = 1'b1;
      case (b)
         "=": op = T_EQ;
         "+": op = T_PLUS;
         "*": op = T_STAR;
         "/": op = T_SLASH;
         "%": op = T_PCT;
         "(": op = T_LPAREN;
         ")": op = T_RPAREN;
         ",": op = T_COMMA;
         ".": op = T_DOT;
         ";": op = T_SEMI;
         default: begin
            op = T_UNKNOWN;
            is_op = 1'b0;
         end
      endcase
      mode = M_IDLE;
      if (blank_ch(b)) begin
         step_pos(b);
         return;
      end
      st_line = cur_line;
      st_col = cur_col;
      lex_cnt = 16'd0;
      step_pos(b);
      if (b == CH_MINUS) mode = M_MINUS;
      else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
         dq = (b == CH_DQUOTE);
         mode = M_STR;
      end else if (b == CH_LT) mode = M_LT;
      else if (b == CH_GT) mode = M_GT;
      else if (b == CH_BANG) mode = M_BANG;
      else if (digit_ch(b)) begin
         cur_col = up16(cur_col);
         count_byte(b);
         mode = M_INT;
      end else if (alpha_ch(b)) begin
         cur_col = up16(cur_col);
         add_ident(b);
         mode = M_IDENT;
      end else begin
         put_byte(b);
         if (is_op) put_rec(op, st_col, 16'd1);
         else put_rec(T_UNKNOWN, up16(st_col), 16'd1);
      end
   endtask

   task automatic pair_token(input logic [7:0] first, input logic [7:0] b,
                             input logic [5:0] typ);
      step_pos(b);
      put_byte(first);
      put_byte(b);
      put_rec(typ, st_col, 16'd2);
      mode = M_IDLE;
   endtask

   // Resolve whatever token is pending
   task automatic flush_token();
      case (mode)
         M_MINUS: begin put_byte(CH_MINUS); put_rec(T_MINUS, st_col, 16'd1); end
         M_LT:    begin put_byte(CH_LT); put_rec(T_LT, st_col, 16'd1); end
         M_GT:    begin put_byte(CH_GT); put_rec(T_GT, st_col, 16'd1); end
         M_BANG:  begin put_byte(CH_BANG); put_rec(T_UNKNOWN, up16(st_col), 16'd1); end
         M_STR, M_ESC: put_rec(T_STRING, up16(st_col), lex_cnt);
         M_IDENT: close_ident();
         M_INT, M_FRAC, M_EXPS, M_EXP: put_rec(T_NUMBER, up16(st_col), lex_cnt);
         M_DOT: begin
            put_rec(T_NUMBER, up16(st_col), lex_cnt);
            put_byte(CH_DOT);
            put_rec(T_DOT, dot_col, 16'd1);
         end
         default: ;
      endcase
      mode = M_IDLE;
   endtask

   task automatic end_number_then(input logic [7:0] b);
      put_rec(T_NUMBER, up16(st_col), lex_cnt);
      begin_token(b);
   endtask

   // Predict the results of one request and queue them
   task automatic scan_request(input bit cmd, input logic [7:0] b);
      run_items.delete();
      if (cmd == CMD_END) begin
         flush_token();
         st_line = cur_line;
         put_rec(T_END, cur_col, 16'd0);
         lex_reset();
      end else begin
         case (mode)
            M_COMMENT: if (b == CH_LF) begin_token(b); else step_pos(b);
            M_MINUS:
               if (b == CH_MINUS) begin step_pos(b); mode = M_COMMENT; end
               else begin flush_token(); begin_token(b); end
            M_LT:
               if (b == CH_EQ) pair_token(CH_LT, b, T_LE);
               else if (b == CH_GT) pair_token(CH_LT, b, T_NE);
               else begin flush_token(); begin_token(b); end
            M_GT:
               if (b == CH_EQ) pair_token(CH_GT, b, T_GE);
               else begin flush_token(); begin_token(b); end
            M_BANG:
               if (b == CH_EQ) pair_token(CH_BANG, b, T_NE);
               else begin flush_token(); begin_token(b); end
            M_STR: begin
               step_pos(b);
               if (b == (dq ? CH_DQUOTE : CH_SQUOTE)) begin
                  put_rec(T_STRING, up16(st_col), lex_cnt);
                  mode = M_IDLE;
               end else if (b == CH_BSLASH) mode = M_ESC;
               else count_byte(b);
            end
            M_ESC: begin
               step_pos(b);
               count_byte(b == CH_LOW_N ? CH_LF : b == CH_LOW_T ? CH_TAB :
                          b == CH_LOW_R ? CH_CR : b);
               mode = M_STR;
            end
            M_IDENT:
               if (alpha_ch(b) || digit_ch(b)) begin step_pos(b); add_ident(b); end
               else begin close_ident(); begin_token(b); end
            M_INT:
               if (digit_ch(b)) begin step_pos(b); count_byte(b); end
               else if (b == CH_DOT) begin dot_col = cur_col; step_pos(b); mode = M_DOT; end
               else if (b == CH_LOW_E || b == CH_UP_E) begin
                  step_pos(b); count_byte(b); mode = M_EXPS;
               end else end_number_then(b);
            M_DOT:
               if (digit_ch(b)) begin
                  count_byte(CH_DOT);
                  step_pos(b);
                  count_byte(b);
                  mode = M_FRAC;
               end else begin flush_token(); begin_token(b); end
            M_FRAC:
               if (digit_ch(b)) begin step_pos(b); count_byte(b); end
               else if (b == CH_LOW_E || b == CH_UP_E) begin
                  step_pos(b); count_byte(b); mode = M_EXPS;
               end else end_number_then(b);
            M_EXPS:
               if (b == CH_PLUS || b == CH_MINUS || digit_ch(b)) begin
                  step_pos(b); count_byte(b); mode = M_EXP;
               end else end_number_then(b);
            M_EXP:
               if (digit_ch(b)) begin step_pos(b); count_byte(b); end
               else end_number_then(b);
            default: begin_token(b);
         endcase
      end
      if (run_items.size() > 0) run_items[run_items.size()-1].last = 1'b1;
      foreach (run_items[i]) tokens_expected.insert(tokens_expected.size(), run_items[i]);
   endtask

   task automatic add_request(input bit cmd, input logic [7:0] b, input int phase);
      request_type r;
      r = '{cmd, b, phase};
      requests.insert(requests.size(), r);
      scan_request(cmd, b);
   endtask

   task automatic add_text(input string s, input int phase);
      for (int i = 0; i < s.len(); i++) add_request(CMD_BYTE, s[i], phase);
   endtask

   task automatic check_record(input logic [5:0] typ, input int line, input int col,
                               input int len);
      if (last_record.typ != typ) report("table type", typ, last_record.typ);
      if (last_record.line != line) report("table line", line, last_record.line);
      if (last_record.col != col) report("table column", col, last_record.col);
      if (last_record.len != len) report("table length", len, last_record.len);
   endtask

   function automatic string random_case(input string s);
      string t;
      t = s;
      for (int i = 0; i < t.len(); i++)
         if ($urandom_range(1) && t[i] >= "A" && t[i] <= "Z") t[i] = t[i] + 8'd32;
      return t;
   endfunction

   function automatic byte word_char(input bit first);
      int k;
      k = $urandom_range(first ? 52 : 62);
      if (k < 26) return byte'("a" + k);
      if (k < 52) return byte'("A" + k - 26);
      if (k == 52) return "_";
      return byte'("0" + k - 53);
   endfunction

   function automatic string digits();
      string s;
      s = "";
      repeat ($urandom_range(1, 4)) s = {s, string'(byte'("0" + $urandom_range(9)))};
      return s;
   endfunction

   // One random fragment of mostly well-formed SQL
   task automatic add_fragment(input int phase);
      string s;
      string ops [17] = '{"<=", "<>", "!=", "<", ">=", ">", "=", "+", "-", "*", "/",
                          "%", "(", ")", ",", ".", ";"};
      byte   q;
      int    pick;
      s = "";
      pick = $urandom_range(99);
      if (pick < 18) s = random_case(keywords[$urandom_range(31)]);
      else if (pick < 30) begin
         s = {s, string'(word_char(1))};
         repeat ($urandom_range(0, 11)) s = {s, string'(word_char(0))};
      end else if (pick < 44) begin
         s = digits();
         if ($urandom_range(2) == 0) s = {s, ".", digits()};
         else if ($urandom_range(4) == 0) s = {s, "."};
         if ($urandom_range(2) == 0) begin
            s = {s, string'($urandom_range(1) ? CH_LOW_E : CH_UP_E)};
            case ($urandom_range(2))
               0: s = {s, "+"};
               1: s = {s, "-"};
               default: ;
            endcase
            s = {s, digits()};
         end
      end else if (pick < 56) begin
         q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
         s = {string'(q)};
         repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(5))
               0: s = {s, "\\", string'(byte'($urandom_range(32, 126)))};
               1: s = {s, "\n"};
               2: s = {s, "\\", string'($urandom_range(1) ? CH_LOW_N : CH_LOW_T)};
               default: s = {s, string'(byte'($urandom_range(32, 126)))};
            endcase
         end
         if ($urandom_range(4) != 0) s = {s, string'(q)};
      end else if (pick < 74) s = ops[$urandom_range(16)];
      else if (pick < 82) s = {string'(byte'($urandom_range(1) ? CH_SPACE : $urandom_range(9, 13)))};
      else if (pick < 86) s = {"-- ", digits(), "\n"};
      else if (pick < 96) begin
         add_request(CMD_BYTE, 8'($urandom_range(255)), phase);
         return;
      end else begin
         add_request(CMD_END, 8'($urandom_range(255)), phase);
         return;
      end
      add_text(s, phase);
      if ($urandom_range(2) == 0) add_request(CMD_BYTE, CH_SPACE, phase);
   endtask

   // Build the whole request stream and its expected results up front
   task automatic build_requests();
      int n;
      lex_reset();
      foreach (plan[r]) begin
         if (plan[r].raw >= 0) add_request(CMD_BYTE, 8'(plan[r].raw), 0);
         else add_text(plan[r].text, 0);
         if (plan[r].eoi) add_request(CMD_END, 8'd0, 0);
         if (plan[r].chk) check_record(plan[r].typ, plan[r].line, plan[r].col, plan[r].len);
      end
      random_start = requests.size();
      n = 0;
      while (requests.size() - random_start < 100) begin
         add_fragment((n / 6) % 4);
         n++;
      end
      add_request(CMD_END, 8'd0, 3);
   endtask

   // Sender
   initial begin
      int idx;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = 1'b0;
      req_input_byte = 8'd0;
      errors = 0;
      results_seen = 0;
      records_seen = 0;
      src_idle_pct = 0;
      dst_stall_pct = 0;
      want_hold = 1'b0;
      build_requests();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      idx = 0;
      while (idx < requests.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) idx++;
         if (req_valid && req_stall) continue;
         if (idx < requests.size()) begin
            src_idle_pct = requests[idx].phase == 1 ? 56 : requests[idx].phase == 3 ? 23 : 0;
            dst_stall_pct = requests[idx].phase == 2 ? 56 : requests[idx].phase == 3 ? 23 : 0;
            if (idx == random_start && !want_hold) want_hold = 1'b1;
         end
         if (idx < requests.size() && $urandom_range(99) >= src_idle_pct) begin
            req_valid <= 1'b1;
            req_command <= requests[idx].cmd;
            req_input_byte <= requests[idx].data;
         end else begin
            req_valid <= 1'b0;
         end
      end
      while (tokens_expected.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d requests (directed table, random SQL); checked %0d results",
               requests.size(), results_seen);
      $display("including %0d token records, with sender gaps, receiver stalls and a hold-off",
               records_seen);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver stall, with one long hold-off to fill the run queue
   initial rsp_stall = 1'b0;
   always @(posedge clock) begin
      if (want_hold && hold_left == 0) begin
         want_hold = 1'b0;
         hold_left = 80;
      end
      if (reset) rsp_stall <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else rsp_stall <= $urandom_range(99) < dst_stall_pct;
   end

   // Result checker
   always @(posedge clock) begin
      lexeme_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_item_kind == KIND_RECORD) records_seen++;
         if (tokens_expected.size() == 0) report("unexpected result, kind", -1, rsp_item_kind);
         else begin
            e = tokens_expected.pop_front();
            if (rsp_item_kind != e.kind) report("item_kind", e.kind, rsp_item_kind);
            if (rsp_value_byte != e.val) report("value_byte", e.val, rsp_value_byte);
            if (rsp_token_type != e.typ) report("token_type", e.typ, rsp_token_type);
            if (rsp_token_line != e.line) report("token_line", e.line, rsp_token_line);
            if (rsp_token_column != e.col) report("token_column", e.col, rsp_token_column);
            if (rsp_token_length != e.len) report("token_length", e.len, rsp_token_length);
            if (rsp_last_of_run != e.last) report("last_of_run", e.last, rsp_last_of_run);
         end
      end
   end

   // Watchdog
   initial begin
      cycles = 0;
      hold_left = 0;
   end
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                  tokens_expected.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
`default_nettype wire

### sql_token_scanner_top.f
hw/rtl/sts_pkg.sv
hw/rtl/sts_front.sv
hw/rtl/sts_queue.sv
hw/rtl/sts_back.sv
hw/rtl/sql_token_scanner_top.sv
tb/sv/sql_token_scanner_top_tb.sv
